>>> sv/phcl_pkg.sv
// Shared types and constants for the program image header check loader.
// No dependencies; imported by every module of the block.
`default_nettype none

package phcl_pkg;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_MEMORY_BASE      = 2'd0;
  localparam logic [1:0] REG_MEMORY_LENGTH    = 2'd1;
  localparam logic [1:0] REG_EXPECTED_MAGIC   = 2'd2;
  localparam logic [1:0] REG_EXPECTED_VERSION = 2'd3;

  localparam int unsigned PADDR_W = 4;

  // Load status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_BAD_ENTRY = 3'd3;
  localparam logic [2:0] ST_NO_MEM    = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  // Result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Header bytes that carry fields (six little-endian words)
  localparam int unsigned HDR_FIELD_BYTES = 24;
  localparam int unsigned HDR_WORDS       = 6;

  // Result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;
  localparam int unsigned RQ_CW    = 3;

  typedef struct packed {
    logic [31:0] memory_base;
    logic [31:0] memory_length;
    logic [31:0] expected_magic;
    logic [7:0]  expected_version;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic [2:0]  load_status;
    logic [31:0] entry_address;
    logic [31:0] required_kb;
    logic [21:0] available_kb;
    logic        last_of_run;
  } result_t;

  // Results produced by one item: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

>>> sv/phcl_if.sv
// Handshake channel interfaces: file byte input and load result output.
// Depends on nothing but the language.
`default_nettype none

interface load_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface load_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic [2:0]  load_status;
  logic [31:0] entry_address;
  logic [31:0] required_kb;
  logic [21:0] available_kb;
  logic        last_of_run;

  modport source (output valid, output result_kind, output write_address,
                  output write_data, output load_status, output entry_address,
                  output required_kb, output available_kb, output last_of_run,
                  input ready);
  modport sink (input valid, input result_kind, input write_address,
                input write_data, input load_status, input entry_address,
                input required_kb, input available_kb, input last_of_run,
                output ready);
endinterface

`default_nettype wire

>>> sv/program_image_header_check_loader.sv
// Flow: an accepted item lands in the input register, is checked and
// queued in the result queue, from which its first result is offered.
// Throughput: one file byte per cycle while the queue has room; a byte that
// closes the image gives two results, which leave the four-entry result queue one at a time.
// Reset: synchronous, active high; registers read 0, load restarts at header.
// Top level; depends on phcl_pkg, phcl_if, phcl_cfg, phcl_core and phcl_rq.
`default_nettype none

module program_image_header_check_loader
  import phcl_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 32   // 24 to 128
) (
  input  wire logic               clk,
  input  wire logic               rst,
  load_in_if.sink                 file_in,
  load_out_if.source              result_out,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t  cfg;
  push_t push;
  logic  room;

  // Registers: base, length, magic, version at byte addresses 0, 4, 8, 12.
  // Values are sampled by the core whenever a byte is processed, so the
  // header check uses those held when the header completes.
  phcl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Core: one file byte per cycle. Header words are built in place; on the
  // last header byte the check runs on the completed words and either queues
  // a status or starts the image. Image bytes become writes at
  // base + load offset + index; the closing byte adds OK or truncated.
  // The core holds its item until the queue has space for two results.
  phcl_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .file_in (file_in),
    .cfg     (cfg),
    .room    (room),
    .push    (push)
  );

  // Result queue separates the two sides, so bytes keep flowing while a
  // finished result waits to be taken.
  phcl_rq u_rq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

>>> sv/phcl_cfg.sv
// APB-style configuration registers of the loader.
// Depends on phcl_pkg.
`default_nettype none

module phcl_cfg
  import phcl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MEMORY_BASE:      cfg.memory_base      <= pwdata;
        REG_MEMORY_LENGTH:    cfg.memory_length    <= pwdata;
        REG_EXPECTED_MAGIC:   cfg.expected_magic   <= pwdata;
        REG_EXPECTED_VERSION: cfg.expected_version <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MEMORY_BASE:      prdata = cfg.memory_base;
      REG_MEMORY_LENGTH:    prdata = cfg.memory_length;
      REG_EXPECTED_MAGIC:   prdata = cfg.expected_magic;
      REG_EXPECTED_VERSION: prdata = {24'd0, cfg.expected_version};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/phcl_core.sv
// Input register, header gathering/checking and image address generation.
// Depends on phcl_pkg and phcl_if.
`default_nettype none

module phcl_core
  import phcl_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  load_in_if.sink    file_in,
  input  cfg_t       cfg,
  input  wire logic  room,
  output push_t      push
);

  localparam logic [31:0] HDR_LAST  = 32'(HEADER_BYTES - 1);
  localparam logic [7:0]  HDR_SIZE8 = 8'(HEADER_BYTES);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_IMAGE,
    PH_DRAIN
  } phase_t;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eof;

  phase_t      phase, phase_next;
  logic [31:0] byte_counter, byte_counter_next;
  logic [31:0] img_off, img_off_next;
  logic [31:0] hdr [HDR_WORDS];
  logic [31:0] hdr_next [HDR_WORDS];
  logic [31:0] required_kb, required_kb_next;
  logic [21:0] available_kb, available_kb_next;

  logic        fire;
  logic        hdr_field;
  logic [2:0]  widx;
  logic [31:0] room_len, load_end, cnt_inc;
  logic        bad_hdr, bad_size, bad_entry, no_mem, hdr_done, img_done;
  logic [2:0]  check_st;
  logic [21:0] avail;
  result_t     r_write, r_status;

  assign fire          = in_valid && room;
  assign file_in.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (file_in.ready) begin
      in_valid <= file_in.valid;
    end
    if (file_in.ready && file_in.valid) begin
      in_byte <= file_in.file_byte;
      in_eof  <= file_in.end_of_file;
    end
  end

  // header byte insertion
  assign hdr_field = (byte_counter < 32'(HDR_FIELD_BYTES));
  assign widx      = byte_counter[4:2];

  always_comb begin
    for (int i = 0; i < HDR_WORDS; i++) begin
      hdr_next[i] = hdr[i];
    end
    if (phase == PH_HEADER && hdr_field) begin
      hdr_next[widx][8*byte_counter[1:0] +: 8] = in_byte;
    end
  end

  // header check, on completed words
  assign room_len = cfg.memory_length - hdr_next[2];
  assign load_end = hdr_next[2] + hdr_next[3];
  assign avail    = cfg.memory_length[31:10];
  assign bad_hdr  = (hdr_next[0] != cfg.expected_magic) ||
                    (hdr_next[1][7:0] != cfg.expected_version) ||
                    (hdr_next[1][15:8] != HDR_SIZE8) ||
                    (hdr_next[1][31:16] != 16'd0);
  assign bad_size = (hdr_next[3] == 32'd0) || (hdr_next[2] > cfg.memory_length) ||
                    (hdr_next[3] > room_len);
  assign bad_entry = (hdr_next[4] < hdr_next[2]) || (hdr_next[4] >= load_end);
  assign no_mem    = (hdr_next[5] != 32'd0) && (hdr_next[5] > {10'd0, avail});

  always_comb begin
    if (bad_hdr)        check_st = ST_BAD_HDR;
    else if (bad_size)  check_st = ST_BAD_SIZE;
    else if (bad_entry) check_st = ST_BAD_ENTRY;
    else if (no_mem)    check_st = ST_NO_MEM;
    else if (in_eof)    check_st = ST_TRUNC;
    else                check_st = ST_OK;
  end

  assign hdr_done = (byte_counter == HDR_LAST);
  assign cnt_inc  = byte_counter + 32'd1;
  assign img_done = (cnt_inc >= hdr[3]);

  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    img_off_next      = img_off;
    required_kb_next  = required_kb;
    available_kb_next = available_kb;

    r_write               = '0;
    r_write.result_kind   = KIND_WRITE;
    r_write.write_address = cfg.memory_base + img_off;
    r_write.write_data    = in_byte;
    r_status              = '0;
    r_status.result_kind  = KIND_STATUS;
    r_status.last_of_run  = 1'b1;
    push.count            = 2'd0;

    case (phase)
      PH_HEADER: begin
        if (hdr_done) begin
          byte_counter_next = '0;
          img_off_next      = hdr_next[2];
          if (!bad_hdr && !bad_size && !bad_entry && hdr_next[5] != 32'd0) begin
            required_kb_next  = hdr_next[5];
            available_kb_next = avail;
          end
          if (check_st == ST_OK) begin
            phase_next = PH_IMAGE;
          end else begin
            r_status.load_status = check_st;
            push.count = 2'd1;
            phase_next = in_eof ? PH_HEADER : PH_DRAIN;
          end
        end else if (in_eof) begin
          r_status.load_status = ST_BAD_HDR;
          push.count           = 2'd1;
          byte_counter_next    = '0;
        end else begin
          byte_counter_next = cnt_inc;
        end
      end
      PH_IMAGE: begin
        byte_counter_next = cnt_inc;
        img_off_next      = img_off + 32'd1;
        if (img_done) begin
          r_status.load_status   = ST_OK;
          r_status.entry_address = cfg.memory_base + hdr[4];
          push.count             = 2'd2;
          phase_next             = in_eof ? PH_HEADER : PH_DRAIN;
          byte_counter_next      = '0;
        end else if (in_eof) begin
          r_status.load_status = ST_TRUNC;
          push.count           = 2'd2;
          phase_next           = PH_HEADER;
          byte_counter_next    = '0;
        end else begin
          r_write.last_of_run = 1'b1;
          push.count          = 2'd1;
        end
      end
      default: begin
        if (in_eof) begin
          phase_next        = PH_HEADER;
          byte_counter_next = '0;
        end
      end
    endcase

    // recorded KB values travel in every result, as updated by this item
    r_write.required_kb   = required_kb_next;
    r_write.available_kb  = available_kb_next;
    r_status.required_kb  = required_kb_next;
    r_status.available_kb = available_kb_next;

    if (!fire) begin
      push.count = 2'd0;
    end
    push.first  = (phase == PH_IMAGE) ? r_write : r_status;
    push.second = r_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_counter <= '0;
      img_off      <= '0;
      required_kb  <= '0;
      available_kb <= '0;
      for (int i = 0; i < HDR_WORDS; i++) begin
        hdr[i] <= '0;
      end
    end else if (fire) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      img_off      <= img_off_next;
      required_kb  <= required_kb_next;
      available_kb <= available_kb_next;
      for (int i = 0; i < HDR_WORDS; i++) begin
        hdr[i] <= hdr_next[i];
      end
    end
  end

  // two results only come from an image byte
  a_pair_from_image: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> phase == PH_IMAGE)
    else $error("result pair outside image phase");

  // in a pair the status closes the run
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (push.first.result_kind == KIND_WRITE) &&
      !push.first.last_of_run && push.second.result_kind == KIND_STATUS)
    else $error("result pair out of order");

  // every end of file returns to header gathering at byte zero
  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && in_eof |=> phase == PH_HEADER && byte_counter == 32'd0)
    else $error("end of file did not restart header gathering");

endmodule

`default_nettype wire

>>> sv/phcl_rq.sv
// Result queue: takes up to two results a cycle, hands out one.
// Depends on phcl_pkg and phcl_if.
`default_nettype none

module phcl_rq
  import phcl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  push_t      push,
  output logic       room,
  load_out_if.source result_out
);

  result_t          mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr, rd_ptr;
  logic [RQ_CW-1:0] count;
  logic             pop;
  result_t          head;

  assign room = (count <= RQ_CW'(RQ_DEPTH - 2));
  assign pop  = result_out.valid && result_out.ready;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + RQ_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_AW'(push.count);
      rd_ptr <= rd_ptr + RQ_AW'(pop);
      count  <= count + RQ_CW'(push.count) - RQ_CW'(pop);
    end
  end

  assign result_out.valid         = (count != '0);
  assign result_out.result_kind   = head.result_kind;
  assign result_out.write_address = head.write_address;
  assign result_out.write_data    = head.write_data;
  assign result_out.load_status   = head.load_status;
  assign result_out.entry_address = head.entry_address;
  assign result_out.required_kb   = head.required_kb;
  assign result_out.available_kb  = head.available_kb;
  assign result_out.last_of_run   = head.last_of_run;

endmodule

`default_nettype wire
